/* design/swfs_pkg.sv */
// Shared types, constants and status codes for the SpO2 window / FiO2 stepper.
package swfs_pkg;

  localparam int WIN_W  = 8;
  localparam int SPO2_W = 7;
  localparam int FIO2_W = 7;
  localparam int STAT_W = 4;
  localparam int SUM_W  = 15;
  localparam int ACMD_W = 2;

  localparam int MAX_WINDOW = 255;

  // divider: dividend 2*sum+n, divisor 2*n
  localparam int DIV_W     = SUM_W + 2;
  localparam int DEN_W     = WIN_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPO2_MIN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPO2_MAX  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPO2_MID  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FIO2_MIN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FIO2_MAX  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INIT_FIO2 = 3'd6;

  localparam logic [WIN_W-1:0]  RST_WINDOW    = 8'd30;
  localparam logic [SPO2_W-1:0] RST_SPO2_MIN  = 7'd88;
  localparam logic [SPO2_W-1:0] RST_SPO2_MAX  = 7'd95;
  localparam logic [SPO2_W-1:0] RST_SPO2_MID  = 7'd91;
  localparam logic [FIO2_W-1:0] RST_FIO2_MIN  = 7'd21;
  localparam logic [FIO2_W-1:0] RST_FIO2_MAX  = 7'd100;
  localparam logic [FIO2_W-1:0] RST_INIT_FIO2 = 7'd21;

  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_OVERRIDE = 1'b1;

  localparam logic [STAT_W-1:0] ST_MIDDLE     = 4'd0;
  localparam logic [STAT_W-1:0] ST_MID_BELOW  = 4'd1;
  localparam logic [STAT_W-1:0] ST_MID_HIGH   = 4'd2;
  localparam logic [STAT_W-1:0] ST_BELOW_L1   = 4'd3;
  localparam logic [STAT_W-1:0] ST_BELOW_AL1  = 4'd4;
  localparam logic [STAT_W-1:0] ST_BELOW_L2   = 4'd5;
  localparam logic [STAT_W-1:0] ST_HIGH_L1    = 4'd6;
  localparam logic [STAT_W-1:0] ST_HIGH_AL1   = 4'd7;
  localparam logic [STAT_W-1:0] ST_HIGH_L2    = 4'd8;
  localparam logic [STAT_W-1:0] ST_ALARM      = 4'd9;

  localparam logic [ACMD_W-1:0] ALARM_KEEP    = 2'd0;
  localparam logic [ACMD_W-1:0] ALARM_ENABLE  = 2'd1;
  localparam logic [ACMD_W-1:0] ALARM_DISABLE = 2'd2;

  localparam logic [SPO2_W-1:0] AVG_FLOOR = 7'd21;
  localparam logic [SPO2_W-1:0] AVG_CEIL  = 7'd100;
  localparam logic [SPO2_W:0]   BAND_GAP  = 8'd3;
  localparam logic [FIO2_W-1:0] STEP_BIG  = 7'd6;
  localparam logic [FIO2_W-1:0] STEP_MID  = 7'd4;
  localparam logic [FIO2_W-1:0] STEP_SML  = 7'd2;
  localparam logic [FIO2_W:0]   FIO2_SAT  = 8'd127;

  typedef struct packed {
    logic [WIN_W-1:0]  window_length;
    logic [SPO2_W-1:0] spo2_minimum;
    logic [SPO2_W-1:0] spo2_maximum;
    logic [SPO2_W-1:0] spo2_middle;
    logic [FIO2_W-1:0] fio2_minimum;
    logic [FIO2_W-1:0] fio2_maximum;
  } cfg_t;

  // one entry of the front/back queue: a closed window or a status override
  typedef struct packed {
    logic              override;
    logic [SUM_W-1:0]  sum;
    logic [WIN_W-1:0]  count;
    logic [STAT_W-1:0] status_value;
  } job_t;

endpackage

/* design/swfs_if.sv */
// Valid/ready channel interfaces for the input beats and the result beats.
interface swfs_in_if;
  import swfs_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [SPO2_W-1:0] spo2_sample;
  logic [STAT_W-1:0] status_value;

  modport source (output valid, command, spo2_sample, status_value, input ready);
  modport sink   (input valid, command, spo2_sample, status_value, output ready);
endinterface

interface swfs_out_if;
  import swfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [SPO2_W-1:0] average_spo2;
  logic [STAT_W-1:0] status;
  logic [FIO2_W-1:0] fio2_target;
  logic              valve_update;
  logic [SPO2_W-1:0] baseline_spo2;
  logic              baseline_saved;
  logic              clear_level_timer;
  logic              clear_response_timer;
  logic [ACMD_W-1:0] alarm_timer_cmd;

  modport source (output valid, average_spo2, status, fio2_target, valve_update,
                  baseline_spo2, baseline_saved, clear_level_timer,
                  clear_response_timer, alarm_timer_cmd, input ready);
  modport sink   (input valid, average_spo2, status, fio2_target, valve_update,
                  baseline_spo2, baseline_saved, clear_level_timer,
                  clear_response_timer, alarm_timer_cmd, output ready);
endinterface

/* design/spo2_window_fio2_stepper.sv */
// Top level of the SpO2 window averager and FiO2 target stepper.
// Each input beat is either a saturation sample (command 0) or a status override
// (command 1). Samples are summed in the front end; a sample that does not close the
// window is absorbed in its cycle and gives no result. When the count reaches
// window_length (0 acts as 1) the sum and count go into a two-entry queue and the
// decision engine takes them: it pops the job, runs the bit-serial divider that forms
// round-half-up avg = (2*sum+n)/(2*n) at one bit per cycle, then runs the rule base
// and loads the result register. The front keeps taking beats while the queue has
// room; the engine pops and divides while a finished result waits in the output
// register, but holds at the rule base until that result is taken. Overrides with
// codes 10..15 are dropped; valid ones pass through the queue so they land in order
// with decisions.
// Configuration goes through the APB port, 32-bit registers at 4*index: window
// length, SpO2 min/max/middle, FiO2 min/max and initial FiO2 (writing it also loads
// the live FiO2 target). Write registers only while the block is idle.
module spo2_window_fio2_stepper (
  input  logic                                  clk,
  input  logic                                  rst_n,
  swfs_in_if.sink                               in_chan,
  swfs_out_if.source                            out_chan,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [swfs_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [swfs_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [swfs_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);
  import swfs_pkg::*;

  logic [WIN_W-1:0]  window_r;
  logic [SPO2_W-1:0] spo2_min_r, spo2_max_r, spo2_mid_r;
  logic [FIO2_W-1:0] fio2_min_r, fio2_max_r, init_fio2_r;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 load_fio2;
  cfg_t                 cfg;

  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, pop_job;

  // APB: always ready, write lands on the access phase
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign load_fio2  = wr_en && (reg_idx == REG_INIT_FIO2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= RST_WINDOW;
      spo2_min_r  <= RST_SPO2_MIN;
      spo2_max_r  <= RST_SPO2_MAX;
      spo2_mid_r  <= RST_SPO2_MID;
      fio2_min_r  <= RST_FIO2_MIN;
      fio2_max_r  <= RST_FIO2_MAX;
      init_fio2_r <= RST_INIT_FIO2;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW:    window_r    <= cfg_pwdata[WIN_W-1:0];
        REG_SPO2_MIN:  spo2_min_r  <= cfg_pwdata[SPO2_W-1:0];
        REG_SPO2_MAX:  spo2_max_r  <= cfg_pwdata[SPO2_W-1:0];
        REG_SPO2_MID:  spo2_mid_r  <= cfg_pwdata[SPO2_W-1:0];
        REG_FIO2_MIN:  fio2_min_r  <= cfg_pwdata[FIO2_W-1:0];
        REG_FIO2_MAX:  fio2_max_r  <= cfg_pwdata[FIO2_W-1:0];
        REG_INIT_FIO2: init_fio2_r <= cfg_pwdata[FIO2_W-1:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW:    cfg_prdata = {{(CFG_DATA_W-WIN_W){1'b0}}, window_r};
      REG_SPO2_MIN:  cfg_prdata = {{(CFG_DATA_W-SPO2_W){1'b0}}, spo2_min_r};
      REG_SPO2_MAX:  cfg_prdata = {{(CFG_DATA_W-SPO2_W){1'b0}}, spo2_max_r};
      REG_SPO2_MID:  cfg_prdata = {{(CFG_DATA_W-SPO2_W){1'b0}}, spo2_mid_r};
      REG_FIO2_MIN:  cfg_prdata = {{(CFG_DATA_W-FIO2_W){1'b0}}, fio2_min_r};
      REG_FIO2_MAX:  cfg_prdata = {{(CFG_DATA_W-FIO2_W){1'b0}}, fio2_max_r};
      REG_INIT_FIO2: cfg_prdata = {{(CFG_DATA_W-FIO2_W){1'b0}}, init_fio2_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.window_length = window_r;
  assign cfg.spo2_minimum  = spo2_min_r;
  assign cfg.spo2_maximum  = spo2_max_r;
  assign cfg.spo2_middle   = spo2_mid_r;
  assign cfg.fio2_minimum  = fio2_min_r;
  assign cfg.fio2_maximum  = fio2_max_r;

  // front end: window accumulation and beat classification
  swfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .window_length (cfg.window_length),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  swfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back end: divider, rule base, result register
  swfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_chan  (out_chan),
    .cfg       (cfg),
    .load_fio2 (load_fio2),
    .init_fio2 (cfg_pwdata[FIO2_W-1:0]),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop)
  );

endmodule

/* design/swfs_front.sv */
// Front end: takes input beats, accumulates the window, queues decisions and overrides.
module swfs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  swfs_in_if.sink                    in_chan,
  input  logic [swfs_pkg::WIN_W-1:0] window_length,
  input  logic                       q_full,
  output logic                       q_push,
  output swfs_pkg::job_t             q_job
);
  import swfs_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [WIN_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_inc;
  logic [WIN_W-1:0] count_inc;
  logic [WIN_W-1:0] win_eff;
  logic             accept;
  logic             is_sample;
  logic             win_full;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_sample     = (in_chan.command == CMD_SAMPLE);

  // count stays below the window, so it never wraps; 8-bit length is already <= MAX_WINDOW
  assign sum_inc   = sum_r + {{(SUM_W-SPO2_W){1'b0}}, in_chan.spo2_sample};
  assign count_inc = count_r + {{(WIN_W-1){1'b0}}, 1'b1};
  assign win_eff   = (window_length == '0) ? {{(WIN_W-1){1'b0}}, 1'b1} : window_length;
  assign win_full  = (count_inc >= win_eff);

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    q_push    = 1'b0;
    if (accept && is_sample) begin
      if (win_full) begin
        sum_nxt   = '0;
        count_nxt = '0;
        q_push    = 1'b1;
      end else begin
        sum_nxt   = sum_inc;
        count_nxt = count_inc;
      end
    end else if (accept) begin
      // out-of-range override codes are dropped here
      q_push = (in_chan.status_value <= ST_ALARM);
    end
  end

  assign q_job.override     = !is_sample;
  assign q_job.sum          = sum_inc;
  assign q_job.count        = count_inc;
  assign q_job.status_value = in_chan.status_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  a_window_job_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_job.override |-> q_job.count != '0)
    else $error("window job with zero samples");

endmodule

/* design/swfs_queue.sv */
// Short job queue between the front end and the decision engine.
module swfs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  swfs_pkg::job_t push_job,
  input  logic           pop,
  output swfs_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);
  import swfs_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + QPTR_W'(1);
    return r;
  endfunction

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (push) mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule

/* design/swfs_back.sv */
// Decision engine: serial rounding divider, status rule base, FiO2 stepping, result register.
module swfs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  swfs_out_if.source                  out_chan,
  input  swfs_pkg::cfg_t              cfg,
  input  logic                        load_fio2,
  input  logic [swfs_pkg::FIO2_W-1:0] init_fio2,
  input  logic                        q_empty,
  input  swfs_pkg::job_t              q_job,
  output logic                        q_pop
);
  import swfs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DECIDE} bstate_t;

  bstate_t              state_r, state_nxt;
  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STAT_W-1:0]    cur_status_r, cur_status_nxt;
  logic [FIO2_W-1:0]    target_r, target_nxt;
  logic [SPO2_W-1:0]    baseline_r, baseline_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [SPO2_W-1:0] o_avg_r, o_avg_nxt;
  logic [STAT_W-1:0] o_status_r, o_status_nxt;
  logic [FIO2_W-1:0] o_fio2_r, o_fio2_nxt;
  logic              o_valve_r, o_valve_nxt;
  logic [SPO2_W-1:0] o_base_r, o_base_nxt;
  logic              o_saved_r, o_saved_nxt;
  logic              o_clr_lvl_r, o_clr_lvl_nxt;
  logic              o_clr_rsp_r, o_clr_rsp_nxt;
  logic [ACMD_W-1:0] o_alarm_r, o_alarm_nxt;

  logic [DEN_W:0]    rem_sh;
  logic              q_bit;
  logic [SPO2_W-1:0] avg;
  logic [SPO2_W:0]   a8, lo8, hi8;
  logic              decide_fire;

  // rule-base results
  logic [STAT_W-1:0] r_status;
  logic [FIO2_W-1:0] r_target;
  logic [SPO2_W-1:0] r_base;
  logic              r_valve, r_saved, r_clr_lvl, r_clr_rsp, r_entry;
  logic [ACMD_W-1:0] r_alarm;

  function automatic logic [FIO2_W-1:0] step_up(input logic [FIO2_W-1:0] v,
                                                input logic [FIO2_W-1:0] d,
                                                input logic [FIO2_W-1:0] fmax);
    logic [FIO2_W:0]   s;
    logic [FIO2_W-1:0] r;
    s = {1'b0, v} + {1'b0, d};
    r = (s > FIO2_SAT) ? FIO2_SAT[FIO2_W-1:0] : s[FIO2_W-1:0];
    if (r > fmax) r = fmax;
    return r;
  endfunction

  function automatic logic [FIO2_W-1:0] step_down(input logic [FIO2_W-1:0] v,
                                                  input logic [FIO2_W-1:0] d,
                                                  input logic [FIO2_W-1:0] fmin);
    logic [FIO2_W-1:0] r;
    r = (v > d) ? (v - d) : '0;
    if (r < fmin) r = fmin;
    return r;
  endfunction

  // restoring divider, one quotient bit per cycle, quotient shifts into num_r
  assign rem_sh = {rem_r, num_r[DIV_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  // num_r holds the quotient once the divider is done
  always_comb begin
    if (num_r > {{(DIV_W-SPO2_W){1'b0}}, AVG_CEIL}) avg = AVG_CEIL;
    else if (num_r < {{(DIV_W-SPO2_W){1'b0}}, AVG_FLOOR}) avg = AVG_FLOOR;
    else avg = num_r[SPO2_W-1:0];
  end

  assign a8  = {1'b0, avg};
  assign lo8 = {1'b0, cfg.spo2_minimum};
  assign hi8 = {1'b0, cfg.spo2_maximum};

  always_comb begin
    r_status  = cur_status_r;
    r_target  = target_r;
    r_base    = baseline_r;
    r_valve   = 1'b0;
    r_saved   = 1'b0;
    r_clr_lvl = 1'b0;
    r_clr_rsp = 1'b0;
    r_alarm   = ALARM_KEEP;
    r_entry   = 1'b0;
    if (a8 < lo8 && cur_status_r != ST_ALARM) begin
      if (a8 + BAND_GAP < lo8) begin
        if (cur_status_r != ST_BELOW_L2) begin
          r_status = ST_BELOW_L2;
          r_target = step_up(target_r, STEP_BIG, cfg.fio2_maximum);
          r_entry  = 1'b1;
        end
      end else if (cur_status_r != ST_BELOW_L1 && cur_status_r != ST_BELOW_AL1) begin
        r_status = ST_BELOW_L1;
        r_target = step_up(target_r, STEP_MID, cfg.fio2_maximum);
        r_entry  = 1'b1;
      end
      if (r_target > cfg.fio2_maximum) r_target = cfg.fio2_maximum;
      r_valve = 1'b1;
    end else if (a8 > hi8 && cur_status_r != ST_ALARM) begin
      if (a8 > hi8 + BAND_GAP) begin
        if (cur_status_r != ST_HIGH_L2) begin
          r_status = ST_HIGH_L2;
          r_target = step_down(target_r, STEP_BIG, cfg.fio2_minimum);
          r_entry  = 1'b1;
        end
      end else if (cur_status_r != ST_HIGH_L1 && cur_status_r != ST_HIGH_AL1) begin
        r_status = ST_HIGH_L1;
        r_target = step_down(target_r, STEP_MID, cfg.fio2_minimum);
        r_entry  = 1'b1;
      end
      if (r_target < cfg.fio2_minimum) r_target = cfg.fio2_minimum;
      r_valve = 1'b1;
    end else if (a8 >= lo8 && a8 <= hi8) begin
      if (avg < cfg.spo2_middle) begin
        if (cur_status_r != ST_MID_BELOW) begin
          r_status  = ST_MID_BELOW;
          r_target  = step_up(target_r, STEP_SML, cfg.fio2_maximum);
          r_clr_lvl = 1'b1;
          r_clr_rsp = 1'b1;
          r_alarm   = ALARM_ENABLE;
        end
      end else if (avg > cfg.spo2_middle) begin
        if (cur_status_r != ST_MID_HIGH) begin
          r_status  = ST_MID_HIGH;
          r_base    = avg;
          r_saved   = 1'b1;
          r_target  = step_down(target_r, STEP_SML, cfg.fio2_minimum);
          r_clr_lvl = 1'b1;
          r_alarm   = ALARM_ENABLE;
        end
      end else begin
        r_status  = ST_MIDDLE;
        r_base    = avg;
        r_saved   = 1'b1;
        r_clr_lvl = 1'b1;
        r_clr_rsp = 1'b1;
        r_alarm   = ALARM_DISABLE;
      end
      r_valve = 1'b1;
    end
    // entry to a low or high band
    if (r_entry) begin
      r_base    = avg;
      r_saved   = 1'b1;
      r_clr_lvl = 1'b1;
      r_clr_rsp = 1'b1;
      r_alarm   = ALARM_ENABLE;
    end
  end

  assign decide_fire = (state_r == S_DECIDE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    cur_status_nxt = cur_status_r;
    target_nxt     = target_r;
    baseline_nxt   = baseline_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    o_avg_nxt      = o_avg_r;
    o_status_nxt   = o_status_r;
    o_fio2_nxt     = o_fio2_r;
    o_valve_nxt    = o_valve_r;
    o_base_nxt     = o_base_r;
    o_saved_nxt    = o_saved_r;
    o_clr_lvl_nxt  = o_clr_lvl_r;
    o_clr_rsp_nxt  = o_clr_rsp_r;
    o_alarm_nxt    = o_alarm_r;
    q_pop          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_job.override) begin
            cur_status_nxt = q_job.status_value;
          end else begin
            num_nxt   = {1'b0, q_job.sum, 1'b0} + {{(DIV_W-WIN_W){1'b0}}, q_job.count};
            den_nxt   = {q_job.count, 1'b0};
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
        num_nxt = {num_r[DIV_W-2:0], q_bit};
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (decide_fire) begin
          cur_status_nxt = r_status;
          target_nxt     = r_target;
          baseline_nxt   = r_base;
          out_valid_nxt  = 1'b1;
          o_avg_nxt      = avg;
          o_status_nxt   = r_status;
          o_fio2_nxt     = r_target;
          o_valve_nxt    = r_valve;
          o_base_nxt     = r_base;
          o_saved_nxt    = r_saved;
          o_clr_lvl_nxt  = r_clr_lvl;
          o_clr_rsp_nxt  = r_clr_rsp;
          o_alarm_nxt    = r_alarm;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (load_fio2) target_nxt = init_fio2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_status_r <= ST_MIDDLE;
      target_r     <= RST_INIT_FIO2;
      baseline_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_status_r <= cur_status_nxt;
      target_r     <= target_nxt;
      baseline_r   <= baseline_nxt;
      out_valid_r  <= out_valid_nxt;
      num_r        <= num_nxt;
      den_r        <= den_nxt;
      rem_r        <= rem_nxt;
      cnt_r        <= cnt_nxt;
      o_avg_r      <= o_avg_nxt;
      o_status_r   <= o_status_nxt;
      o_fio2_r     <= o_fio2_nxt;
      o_valve_r    <= o_valve_nxt;
      o_base_r     <= o_base_nxt;
      o_saved_r    <= o_saved_nxt;
      o_clr_lvl_r  <= o_clr_lvl_nxt;
      o_clr_rsp_r  <= o_clr_rsp_nxt;
      o_alarm_r    <= o_alarm_nxt;
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.average_spo2         = o_avg_r;
  assign out_chan.status               = o_status_r;
  assign out_chan.fio2_target          = o_fio2_r;
  assign out_chan.valve_update         = o_valve_r;
  assign out_chan.baseline_spo2        = o_base_r;
  assign out_chan.baseline_saved       = o_saved_r;
  assign out_chan.clear_level_timer    = o_clr_lvl_r;
  assign out_chan.clear_response_timer = o_clr_rsp_r;
  assign out_chan.alarm_timer_cmd      = o_alarm_r;

  a_status_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    decide_fire |=> o_status_r == cur_status_r && o_base_r == baseline_r)
    else $error("result beat disagrees with held status/baseline");

  a_hold_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_valve_r |-> !o_saved_r && !o_clr_lvl_r && !o_clr_rsp_r
                                  && o_alarm_r == ALARM_KEEP)
    else $error("alarm hold result carries commands");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != '0)
    else $error("divide by zero window");

endmodule
